// File: hdl/vjb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vjb_pkg
// Types and constants shared by the voice jitter buffer modules: request and
// result payloads, outcome codes, register indexes and the control interface.
// ----------------------------------------------------------------------------
package vjb_pkg;

    localparam int CFG_W    = 5;
    localparam int HANDLE_W = 16;
    localparam int ENTRY_W  = HANDLE_W + 1;
    localparam int SIL_BIT  = HANDLE_W;
    localparam int CNT_W    = 32;
    localparam int SEQ_W    = 32;

    localparam logic [CFG_W-1:0] TARGET_RESET   = 5'd3;
    localparam logic [CFG_W-1:0] MAX_FILL_RESET = 5'd3;

    // Register index, taken from paddr bit 2.
    localparam logic REG_TARGET   = 1'b0;
    localparam logic REG_MAX_FILL = 1'b1;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_PLAYOUT = 1'b1;

    localparam logic [2:0] OUT_ACCEPTED = 3'd0;
    localparam logic [2:0] OUT_REJECTED = 3'd1;
    localparam logic [2:0] OUT_VOICE    = 3'd2;
    localparam logic [2:0] OUT_GAP_SIL  = 3'd3;
    localparam logic [2:0] OUT_UNDERRUN = 3'd4;

    typedef struct packed {
        logic                action;
        logic [SEQ_W-1:0]    seq;
        logic                filter_ok;
        logic [HANDLE_W-1:0] frame_handle;
    } item_t;

    typedef struct packed {
        logic [2:0]          outcome;
        logic [HANDLE_W-1:0] out_handle;
        logic [4:0]          queue_depth;
        logic [CNT_W-1:0]    lost_total;
        logic [CNT_W-1:0]    late_drop_total;
        logic [CNT_W-1:0]    underrun_total;
        logic [CNT_W-1:0]    overflow_total;
        logic [CNT_W-1:0]    rejected_total;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       calc;
        logic       load_gap;
        logic       push_sil;
        logic       push_voice;
        logic       mark_seen;
        logic       reject_inc;
        logic       underrun_inc;
        logic       set_playing;
        logic       clr_playing;
        logic       trim;
        logic       pop;
        logic       rd_issue;
        logic       finish;
        logic       from_ring;
        logic [2:0] outcome;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic action;
        logic filter_ok;
        logic sil_zero;
        logic playing;
        logic can_start;
        logic need_trim;
        logic empty;
    } status_t;

endpackage
`default_nettype wire

// File: hdl/vjb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vjb_dp
// Datapath: ring memory with pointers and fill count, sequence reference,
// gap arithmetic and the wrapping statistics counters.
// ----------------------------------------------------------------------------
module vjb_dp #(
    parameter int USABLE_SLOTS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire vjb_pkg::item_t            item,
    input  wire vjb_pkg::cmd_t             cmd,
    input  wire logic [vjb_pkg::CFG_W-1:0] target_depth,
    input  wire logic [vjb_pkg::CFG_W-1:0] max_fill,
    output vjb_pkg::status_t               status,
    output vjb_pkg::result_t               result
);
    import vjb_pkg::*;

    localparam int AW = (USABLE_SLOTS > 1) ? $clog2(USABLE_SLOTS) : 1;
    localparam int FW = $clog2(USABLE_SLOTS + 1);
    localparam int CW = (FW > CFG_W) ? FW : CFG_W;

    logic [ENTRY_W-1:0] mem [USABLE_SLOTS];
    logic [ENTRY_W-1:0] rdata_reg;

    item_t              item_reg;
    logic [SEQ_W-1:0]   delta_reg;
    logic [SEQ_W-1:0]   missing_reg;

    logic [AW-1:0]      wp_reg, wp_next;
    logic [AW-1:0]      rp_reg, rp_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [CFG_W-1:0]   sil_reg, sil_next;
    logic               playing_reg, playing_next;
    logic               seen_reg, seen_next;
    logic [SEQ_W-1:0]   last_seq_reg, last_seq_next;
    logic [CNT_W-1:0]   lost_reg, lost_next;
    logic [CNT_W-1:0]   late_reg, late_next;
    logic [CNT_W-1:0]   underrun_reg, underrun_next;
    logic [CNT_W-1:0]   overflow_reg, overflow_next;
    logic [CNT_W-1:0]   reject_reg, reject_next;

    logic               gap;
    logic [CFG_W-1:0]   fill_n;
    logic               full;
    logic               push_en;
    logic [ENTRY_W-1:0] push_data;
    logic [CW-1:0]      fill_c;
    logic [CW-1:0]      target_c;

    assign fill_c   = CW'(fill_reg);
    assign target_c = CW'(target_depth);
    assign full     = (fill_reg == FW'(USABLE_SLOTS));

    // A forward gap is a difference of at least two with the top bit clear.
    assign gap    = seen_reg && (delta_reg > 32'd1) && !delta_reg[SEQ_W-1];
    assign fill_n = (missing_reg < {{(SEQ_W-CFG_W){1'b0}}, max_fill})
                    ? missing_reg[CFG_W-1:0] : max_fill;

    assign push_en   = cmd.push_sil || cmd.push_voice;
    assign push_data = cmd.push_sil ? {1'b1, {HANDLE_W{1'b0}}}
                                    : {1'b0, item_reg.frame_handle};

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        fill_next     = fill_reg;
        sil_next      = sil_reg;
        playing_next  = playing_reg;
        seen_next     = seen_reg;
        last_seq_next = last_seq_reg;
        lost_next     = lost_reg;
        late_next     = late_reg;
        underrun_next = underrun_reg;
        overflow_next = overflow_reg;
        reject_next   = reject_reg;

        if (cmd.reject_inc)
        begin
            reject_next = reject_reg + 32'd1;
        end
        if (cmd.load_gap)
        begin
            sil_next = gap ? fill_n : '0;
            if (gap)
            begin
                lost_next = lost_reg + missing_reg;
            end
        end
        if (cmd.push_sil)
        begin
            sil_next = sil_reg - CFG_W'(1);
        end
        if (push_en)
        begin
            if (full)
            begin
                overflow_next = overflow_reg + 32'd1;
            end
            else
            begin
                wp_next   = (wp_reg == AW'(USABLE_SLOTS - 1)) ? '0 : wp_reg + AW'(1);
                fill_next = fill_reg + FW'(1);
            end
        end
        if (cmd.mark_seen)
        begin
            seen_next     = 1'b1;
            last_seq_next = item_reg.seq;
        end
        if (cmd.set_playing)
        begin
            playing_next = 1'b1;
        end
        if (cmd.clr_playing)
        begin
            playing_next = 1'b0;
        end
        if (cmd.underrun_inc)
        begin
            underrun_next = underrun_reg + 32'd1;
        end
        if (cmd.pop)
        begin
            rp_next   = (rp_reg == AW'(USABLE_SLOTS - 1)) ? '0 : rp_reg + AW'(1);
            fill_next = fill_reg - FW'(1);
        end
        if (cmd.trim)
        begin
            late_next = late_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            fill_reg     <= '0;
            sil_reg      <= '0;
            playing_reg  <= 1'b0;
            seen_reg     <= 1'b0;
            last_seq_reg <= '0;
            lost_reg     <= '0;
            late_reg     <= '0;
            underrun_reg <= '0;
            overflow_reg <= '0;
            reject_reg   <= '0;
        end
        else
        begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fill_reg     <= fill_next;
            sil_reg      <= sil_next;
            playing_reg  <= playing_next;
            seen_reg     <= seen_next;
            last_seq_reg <= last_seq_next;
            lost_reg     <= lost_next;
            late_reg     <= late_next;
            underrun_reg <= underrun_next;
            overflow_reg <= overflow_next;
            reject_reg   <= reject_next;
        end
    end

    // Payload registers and the ring memory carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.calc)
        begin
            delta_reg   <= item_reg.seq - last_seq_reg;
            missing_reg <= item_reg.seq + ~last_seq_reg;
        end
        if (push_en && !full)
        begin
            mem[wp_reg] <= push_data;
        end
        if (cmd.rd_issue)
        begin
            rdata_reg <= mem[rp_reg];
        end
    end

    assign status.action    = item_reg.action;
    assign status.filter_ok = item_reg.filter_ok;
    assign status.sil_zero  = (sil_reg == '0);
    assign status.playing   = playing_reg;
    assign status.can_start = (fill_c >= target_c);
    assign status.need_trim = (fill_c > target_c);
    assign status.empty     = (fill_reg == '0);

    always_comb
    begin
        result.outcome    = cmd.outcome;
        result.out_handle = '0;
        if (cmd.from_ring)
        begin
            if (rdata_reg[SIL_BIT])
            begin
                result.outcome = OUT_GAP_SIL;
            end
            else
            begin
                result.outcome    = OUT_VOICE;
                result.out_handle = rdata_reg[HANDLE_W-1:0];
            end
        end
        result.queue_depth     = fill_c[4:0];
        result.lost_total      = lost_reg;
        result.late_drop_total = late_reg;
        result.underrun_total  = underrun_reg;
        result.overflow_total  = overflow_reg;
        result.rejected_total  = reject_reg;
    end

endmodule
`default_nettype wire

// File: hdl/vjb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vjb_ctrl
// Controller: sequences one request at a time through decode, gap fill,
// push, trim and pop, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module vjb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             out_free,
    input  wire vjb_pkg::status_t status,
    output logic                  item_ready,
    output vjb_pkg::cmd_t         cmd
);
    import vjb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GAP,
        ST_FILL,
        ST_TRIM,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] outcome_reg, outcome_next;
    logic       from_ring_reg, from_ring_next;

    always_comb
    begin
        state_next     = state_reg;
        outcome_next   = outcome_reg;
        from_ring_next = from_ring_reg;
        item_ready     = 1'b0;
        cmd            = '0;
        cmd.outcome    = outcome_reg;
        cmd.from_ring  = from_ring_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load       = 1'b1;
                    from_ring_next = 1'b0;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.action == ACT_ARRIVAL)
                begin
                    if (!status.filter_ok)
                    begin
                        cmd.reject_inc = 1'b1;
                        outcome_next   = OUT_REJECTED;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        cmd.calc   = 1'b1;
                        state_next = ST_GAP;
                    end
                end
                else if (!status.playing && !status.can_start)
                begin
                    cmd.underrun_inc = 1'b1;
                    outcome_next     = OUT_UNDERRUN;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    cmd.set_playing = !status.playing;
                    state_next      = ST_TRIM;
                end
            end
            ST_GAP:
            begin
                cmd.load_gap = 1'b1;
                state_next   = ST_FILL;
            end
            ST_FILL:
            begin
                // Silence markers go in first, one a cycle, then the voice handle.
                if (!status.sil_zero)
                begin
                    cmd.push_sil = 1'b1;
                end
                else
                begin
                    cmd.push_voice = 1'b1;
                    cmd.mark_seen  = 1'b1;
                    outcome_next   = OUT_ACCEPTED;
                    state_next     = ST_FINISH;
                end
            end
            ST_TRIM:
            begin
                if (status.need_trim)
                begin
                    cmd.trim = 1'b1;
                    cmd.pop  = 1'b1;
                end
                else if (status.empty)
                begin
                    cmd.clr_playing  = 1'b1;
                    cmd.underrun_inc = 1'b1;
                    outcome_next     = OUT_UNDERRUN;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    cmd.rd_issue   = 1'b1;
                    cmd.pop        = 1'b1;
                    from_ring_next = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            outcome_reg   <= OUT_ACCEPTED;
            from_ring_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            outcome_reg   <= outcome_next;
            from_ring_reg <= from_ring_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/voice_jitter_buffer.sv
`default_nettype none
// Request flow: a rejected arrival or a refused playout goes from decode to finish;
// an accepted arrival passes decode, gap and fill, queuing silence markers one a cycle,
// and a playout passes decode and trim (ring walked one a cycle) before finish.
// Throughput: one request at a time, the next taken once the result is registered;
// the output register lets that happen while the result still waits.
// Reset clears pointers, fill, counters and sets both registers to 3; no clearing pass.
// ----------------------------------------------------------------------------
// voice_jitter_buffer
// Voice-frame jitter buffer with gap silence fill, target-depth trimming,
// underrun handling and an APB register port for its two settings.
// ----------------------------------------------------------------------------
module voice_jitter_buffer #(
    parameter int USABLE_SLOTS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire vjb_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output vjb_pkg::result_t      result,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import vjb_pkg::*;

    logic [CFG_W-1:0] target_reg;
    logic [CFG_W-1:0] max_fill_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    cmd_t             cmd;
    status_t          status;
    result_t          dp_result;
    logic             out_free;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RESET;
            max_fill_reg <= MAX_FILL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TARGET:   target_reg   <= pwdata[CFG_W-1:0];
                REG_MAX_FILL: max_fill_reg <= pwdata[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TARGET:   prdata = {{(32-CFG_W){1'b0}}, target_reg};
            REG_MAX_FILL: prdata = {{(32-CFG_W){1'b0}}, max_fill_reg};
            default:      prdata = '0;
        endcase
    end

    assign out_free = !result_valid_reg || result_ready;

    vjb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .out_free   (out_free),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    vjb_dp #(
        .USABLE_SLOTS (USABLE_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .target_depth (target_reg),
        .max_fill     (max_fill_reg),
        .status       (status),
        .result       (dp_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg <= dp_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// File: hdl/vjb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vjb_checker
// Port-level checks on the jitter buffer, bound to the top level.
// ----------------------------------------------------------------------------
module vjb_checker #(
    parameter int USABLE_SLOTS = 16
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_ready,
    input wire logic             result_valid,
    input wire logic             result_ready,
    input wire vjb_pkg::result_t result
);
    import vjb_pkg::*;

    // Requests are handled one at a time, so the input closes after each one.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("request taken while another is in progress");

    a_handle_only_voice: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.outcome != OUT_VOICE)) |-> (result.out_handle == '0))
        else $error("handle shown on a result that is not a voice frame");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((USABLE_SLOTS > 31) || (int'(result.queue_depth) <= USABLE_SLOTS)))
        else $error("queue depth above the ring size");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("result changed or dropped before it was taken");

endmodule

bind voice_jitter_buffer vjb_checker #(
    .USABLE_SLOTS (USABLE_SLOTS)
) u_vjb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire
